@@ design/cfa_pkg.sv @@
// Package for the contiguous fit allocator: store geometry, field types,
// command, policy and status codes, and the controller state encoding.
// No dependencies; every other design file refers to it by scoped names.
package cfa_pkg;

    localparam int unsigned MEM_CELLS = 4096;
    localparam int unsigned IDX_W     = $clog2(MEM_CELLS);
    localparam int unsigned CNT_W     = IDX_W + 1;

    localparam int unsigned OWNER_W  = 16;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned START_W  = 12;
    localparam int unsigned POLICY_W = 2;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [OWNER_W-1:0]  owner_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [START_W-1:0]  start_t;
    typedef logic [POLICY_W-1:0] policy_t;

    // Number of cells, which doubles as the one-past-last index closing a
    // scan, and the index of the last cell.
    localparam cnt_t CELL_COUNT = cnt_t'(MEM_CELLS);
    localparam idx_t LAST_CELL  = idx_t'(MEM_CELLS - 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam policy_t POLICY_FIRST = policy_t'(0);
    localparam policy_t POLICY_BEST  = policy_t'(1);
    localparam policy_t POLICY_WORST = policy_t'(2);

    localparam status_t ST_DONE  = status_t'(0);
    localparam status_t ST_NOFIT = status_t'(1);
    localparam status_t ST_BAD   = status_t'(2);

    localparam owner_t OWNER_FREE = owner_t'(0);

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_CLEAR  = 6'b000100,
        S_SCAN   = 6'b001000,
        S_FILL   = 6'b010000,
        S_RESULT = 6'b100000
    } state_t;

endpackage

@@ design/cfa_if.sv @@
// Channel interfaces of the contiguous fit allocator: request, response
// and configuration write. Depends on cfa_pkg for the payload types.
interface cfa_req_if;
    logic            valid;
    logic            ready;
    logic            cmd;
    cfa_pkg::owner_t owner_id;
    cfa_pkg::size_t  alloc_size;

    modport source (output valid, output cmd, output owner_id, output alloc_size,
                    input ready);
    modport sink   (input valid, input cmd, input owner_id, input alloc_size,
                    output ready);
endinterface

interface cfa_rsp_if;
    logic             valid;
    logic             ready;
    cfa_pkg::status_t status;
    cfa_pkg::start_t  start_index;

    modport source (output valid, output status, output start_index, input ready);
    modport sink   (input valid, input status, input start_index, output ready);
endinterface

interface cfa_cfg_if;
    logic             valid;
    logic             ready;
    cfa_pkg::policy_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/contiguous_fit_allocator.sv @@
// Contiguous fit allocator over a MEM_CELLS-cell (4096) owner store.
// A bad or oversize request goes straight to the result; a clear or an allocate
// first sweeps the whole store, and a granted allocate then writes alloc_size
// cells. One request is in flight at a time, set by the
// single-port scan and write over the cell memory. Reset: policy_reg returns to
// first fit and a clearing pass zeroes the store before any request.
module contiguous_fit_allocator (
    input  logic          clk,
    input  logic          rst_n,
    cfa_cfg_if.sink       cfg,
    cfa_req_if.sink       req,
    cfa_rsp_if.source     rsp
);

    // The cell store: one write port and one registered read port. Every
    // sweep reads strictly ahead of the address it writes, so reads never
    // race writes within a request.
    cfa_pkg::owner_t cell_mem [cfa_pkg::MEM_CELLS];
    cfa_pkg::owner_t mem_rdata_reg;
    cfa_pkg::idx_t   mem_raddr;
    cfa_pkg::idx_t   mem_waddr;
    cfa_pkg::owner_t mem_wdata;
    logic            mem_we;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cell_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= cell_mem[mem_raddr];
    end

    // Controller state.
    cfa_pkg::state_t  state_reg,      state_next;
    cfa_pkg::policy_t policy_reg,     policy_next;

    // Latched request.
    logic             cmd_reg,        cmd_next;
    cfa_pkg::owner_t  owner_reg,      owner_next;
    cfa_pkg::size_t   size_reg,       size_next;

    // Sweep issue side: rd_idx walks 0..MEM_CELLS; the extra step at
    // MEM_CELLS carries no read and closes the last hole.
    cfa_pkg::cnt_t    rd_idx_reg,     rd_idx_next;
    logic             issue_done_reg, issue_done_next;

    // Sweep process side, a register behind the issue side to match the
    // memory's registered read.
    logic             proc_vld_reg,   proc_vld_next;
    cfa_pkg::cnt_t    proc_idx_reg,   proc_idx_next;

    // Hole tracking during an allocate scan.
    cfa_pkg::idx_t    run_start_reg,  run_start_next;
    cfa_pkg::cnt_t    run_len_reg,    run_len_next;
    logic             found_reg,      found_next;
    cfa_pkg::idx_t    pick_start_reg, pick_start_next;
    cfa_pkg::cnt_t    pick_len_reg,   pick_len_next;

    // Run writer.
    cfa_pkg::idx_t    fill_idx_reg,   fill_idx_next;
    cfa_pkg::size_t   fill_left_reg,  fill_left_next;

    // Pending result and the output register.
    cfa_pkg::status_t res_status_reg, res_status_next;
    cfa_pkg::idx_t    res_start_reg,  res_start_next;
    logic             rsp_valid_reg,  rsp_valid_next;
    cfa_pkg::status_t rsp_status_reg, rsp_status_next;
    cfa_pkg::start_t  rsp_start_reg,  rsp_start_next;

    // Scan evaluation signals.
    logic             at_end;
    logic             free_cell;
    logic             run_ok;
    logic             take_run;
    logic             cand_found;
    cfa_pkg::idx_t    cand_start;
    cfa_pkg::cnt_t    cand_len;
    logic             is_best;
    logic             is_worst;
    logic             rsp_free;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == cfa_pkg::S_IDLE);

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.start_index = rsp_start_reg;

    assign rsp_free = !rsp_valid_reg || rsp.ready;

    // A cell position of MEM_CELLS counts as occupied, which ends the last
    // hole of the store. Policy code 3 falls through to first fit, since
    // only best and worst fit ever replace an earlier pick.
    always_comb
    begin
        at_end     = (proc_idx_reg == cfa_pkg::CELL_COUNT);
        free_cell  = !at_end && (mem_rdata_reg == cfa_pkg::OWNER_FREE);
        is_best    = (policy_reg == cfa_pkg::POLICY_BEST);
        is_worst   = (policy_reg == cfa_pkg::POLICY_WORST);
        run_ok     = (run_len_reg != '0) && (run_len_reg >= size_reg);
        take_run   = run_ok && (!found_reg
                                || (is_best  && (run_len_reg < pick_len_reg))
                                || (is_worst && (run_len_reg > pick_len_reg)));
        cand_found = found_reg || run_ok;
        cand_start = take_run ? run_start_reg : pick_start_reg;
        cand_len   = take_run ? run_len_reg   : pick_len_reg;
    end

    always_comb
    begin
        state_next      = state_reg;
        policy_next     = policy_reg;
        cmd_next        = cmd_reg;
        owner_next      = owner_reg;
        size_next       = size_reg;
        rd_idx_next     = rd_idx_reg;
        issue_done_next = issue_done_reg;
        proc_vld_next   = 1'b0;
        proc_idx_next   = proc_idx_reg;
        run_start_next  = run_start_reg;
        run_len_next    = run_len_reg;
        found_next      = found_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        fill_idx_next   = fill_idx_reg;
        fill_left_next  = fill_left_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_status_next = rsp_status_reg;
        rsp_start_next  = rsp_start_reg;

        mem_raddr = rd_idx_reg[cfa_pkg::IDX_W-1:0];
        mem_waddr = proc_idx_reg[cfa_pkg::IDX_W-1:0];
        mem_wdata = cfa_pkg::OWNER_FREE;
        mem_we    = 1'b0;

        if (cfg.valid)
        begin
            policy_next = cfg.data;
        end

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        // Shared sweep issue for clear and scan.
        if ((state_reg == cfa_pkg::S_CLEAR || state_reg == cfa_pkg::S_SCAN)
            && !issue_done_reg)
        begin
            proc_vld_next = 1'b1;
            proc_idx_next = rd_idx_reg;
            if (rd_idx_reg == cfa_pkg::CELL_COUNT)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                rd_idx_next = rd_idx_reg + cfa_pkg::cnt_t'(1);
            end
        end

        unique case (state_reg)
            cfa_pkg::S_INIT:
            begin
                // Post-reset clearing pass, one cell per cycle.
                mem_we    = 1'b1;
                mem_waddr = rd_idx_reg[cfa_pkg::IDX_W-1:0];
                if (rd_idx_reg[cfa_pkg::IDX_W-1:0] == cfa_pkg::LAST_CELL)
                begin
                    state_next = cfa_pkg::S_IDLE;
                end
                rd_idx_next = rd_idx_reg + cfa_pkg::cnt_t'(1);
            end
            cfa_pkg::S_IDLE:
            begin
                rd_idx_next     = '0;
                issue_done_next = 1'b0;
                run_len_next    = '0;
                found_next      = 1'b0;
                pick_start_next = '0;
                pick_len_next   = '0;
                res_start_next  = '0;
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    owner_next = req.owner_id;
                    size_next  = req.alloc_size;
                    if (req.owner_id == cfa_pkg::OWNER_FREE)
                    begin
                        res_status_next = cfa_pkg::ST_BAD;
                        state_next      = cfa_pkg::S_RESULT;
                    end
                    else if (req.cmd == cfa_pkg::CMD_CLEAR)
                    begin
                        state_next = cfa_pkg::S_CLEAR;
                    end
                    else if (req.alloc_size == '0)
                    begin
                        res_status_next = cfa_pkg::ST_BAD;
                        state_next      = cfa_pkg::S_RESULT;
                    end
                    else if (req.alloc_size > cfa_pkg::CELL_COUNT)
                    begin
                        res_status_next = cfa_pkg::ST_NOFIT;
                        state_next      = cfa_pkg::S_RESULT;
                    end
                    else
                    begin
                        state_next = cfa_pkg::S_SCAN;
                    end
                end
            end
            cfa_pkg::S_CLEAR:
            begin
                if (proc_vld_reg)
                begin
                    if (at_end)
                    begin
                        res_status_next = cfa_pkg::ST_DONE;
                        state_next      = cfa_pkg::S_RESULT;
                    end
                    else if (mem_rdata_reg == owner_reg)
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            cfa_pkg::S_SCAN:
            begin
                if (proc_vld_reg)
                begin
                    if (free_cell)
                    begin
                        if (run_len_reg == '0)
                        begin
                            run_start_next = proc_idx_reg[cfa_pkg::IDX_W-1:0];
                        end
                        run_len_next = run_len_reg + cfa_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        // An occupied cell closes the current hole; judge it whole.
                        found_next      = cand_found;
                        pick_start_next = cand_start;
                        pick_len_next   = cand_len;
                        run_len_next    = '0;
                        if (at_end)
                        begin
                            if (cand_found)
                            begin
                                fill_idx_next  = cand_start;
                                fill_left_next = size_reg;
                                res_start_next = cand_start;
                                state_next     = cfa_pkg::S_FILL;
                            end
                            else
                            begin
                                res_status_next = cfa_pkg::ST_NOFIT;
                                state_next      = cfa_pkg::S_RESULT;
                            end
                        end
                    end
                end
            end
            cfa_pkg::S_FILL:
            begin
                mem_we         = 1'b1;
                mem_waddr      = fill_idx_reg;
                mem_wdata      = owner_reg;
                fill_idx_next  = fill_idx_reg + cfa_pkg::idx_t'(1);
                fill_left_next = fill_left_reg - cfa_pkg::size_t'(1);
                if (fill_left_reg == cfa_pkg::size_t'(1))
                begin
                    res_status_next = cfa_pkg::ST_DONE;
                    state_next      = cfa_pkg::S_RESULT;
                end
            end
            cfa_pkg::S_RESULT:
            begin
                // Wait for the output register to be free, then hand over.
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = res_status_reg;
                    rsp_start_next  = (res_status_reg == cfa_pkg::ST_DONE)
                                      ? cfa_pkg::start_t'(res_start_reg) : '0;
                    state_next      = cfa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = cfa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= cfa_pkg::S_INIT;
            policy_reg     <= cfa_pkg::POLICY_FIRST;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            proc_vld_reg   <= 1'b0;
            found_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            policy_reg     <= policy_next;
            rd_idx_reg     <= rd_idx_next;
            issue_done_reg <= issue_done_next;
            proc_vld_reg   <= proc_vld_next;
            found_reg      <= found_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        owner_reg      <= owner_next;
        size_reg       <= size_next;
        proc_idx_reg   <= proc_idx_next;
        run_start_reg  <= run_start_next;
        run_len_reg    <= run_len_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        fill_idx_reg   <= fill_idx_next;
        fill_left_reg  <= fill_left_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        rsp_status_reg <= rsp_status_next;
        rsp_start_reg  <= rsp_start_next;
    end

`ifndef SYNTH
    // The controller is always in exactly one state.
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    // Only the clearing pass, a clear sweep and the run writer touch the store.
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == cfa_pkg::S_INIT || state_reg == cfa_pkg::S_CLEAR
                    || state_reg == cfa_pkg::S_FILL))
        else $error("cell store written outside a sweep");

    // The run writer never runs past the requested length.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cfa_pkg::S_FILL) |-> (fill_left_reg != '0))
        else $error("run writer ran past the requested size");

    // A new response beat only follows the controller handing a result over.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !$past(rsp_valid_reg) && $past(rst_n))
        |-> ($past(state_reg) == cfa_pkg::S_RESULT && cmd_reg == $past(cmd_reg)))
        else $error("response beat appeared without a finished request");
`endif

endmodule

@@ bench/contiguous_fit_allocator_test.sv @@
// Self-checking testbench for the contiguous fit allocator: a directed table,
// then random requests under every placement policy, with random stalls.
// Depends on cfa_pkg, the cfa_*_if interfaces and contiguous_fit_allocator.
module contiguous_fit_allocator_test;

    localparam int CELLS = int'(cfa_pkg::MEM_CELLS);

    // Encoding 3 of the policy register is unused and falls back to first fit.
    localparam cfa_pkg::policy_t POLICY_UNUSED = cfa_pkg::policy_t'(3);
    localparam cfa_pkg::size_t   SIZE_MAX      = '1;

    // Short names for the directed table.
    localparam cfa_pkg::policy_t FIRST = cfa_pkg::POLICY_FIRST;
    localparam cfa_pkg::policy_t BEST  = cfa_pkg::POLICY_BEST;
    localparam cfa_pkg::policy_t WORST = cfa_pkg::POLICY_WORST;
    localparam logic             ALLOC = cfa_pkg::CMD_ALLOC;
    localparam logic             CLEAR = cfa_pkg::CMD_CLEAR;
    localparam cfa_pkg::status_t DONE  = cfa_pkg::ST_DONE;
    localparam cfa_pkg::status_t NOFIT = cfa_pkg::ST_NOFIT;
    localparam cfa_pkg::status_t BAD   = cfa_pkg::ST_BAD;

    // Random owners mostly come from a small pool so that clears hit cells
    // that were really placed, and holes open up again between allocations.
    localparam int OWNER_POOL      = 12;
    localparam int ITEMS_PER_BLOCK = 12;
    localparam int LONG_HOLD       = 12000;
    localparam int DRAIN_CYCLES    = 2 * CELLS + 16;
    localparam int WATCHDOG_LIMIT  = 100000;
    localparam int MAX_REPORTS     = 10;

    typedef struct packed {
        cfa_pkg::status_t status;
        cfa_pkg::start_t  start_index;
    } alloc_result_t;

    // One row of the directed part. Where known is set, the expected result
    // is typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        cfa_pkg::policy_t policy;
        logic             cmd;
        cfa_pkg::owner_t  owner;
        cfa_pkg::size_t   size;
        bit               known;
        cfa_pkg::status_t status;
        cfa_pkg::start_t  start_index;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 24;

    // The rows build a known layout: after the first sixteen rows the free
    // holes are cells 0..9 (ten), 30..34 (five) and 78..4095 (the tail). Best
    // fit must then pick the five-cell hole, worst fit the tail, and the
    // unused policy the earliest hole, as first fit does.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        // Bad requests: owner zero on allocate and on clear, size zero.
        '{FIRST, ALLOC, 16'h0000, 13'd5,    1'b1, BAD,   12'd0},
        '{FIRST, ALLOC, 16'h0001, 13'd0,    1'b1, BAD,   12'd0},
        '{FIRST, CLEAR, 16'h0000, 13'd0,    1'b1, BAD,   12'd0},
        // Oversize: the largest field value, and one cell more than the store.
        '{FIRST, ALLOC, 16'h0001, 13'd8191, 1'b1, NOFIT, 12'd0},
        '{FIRST, ALLOC, 16'h0001, 13'd4097, 1'b1, NOFIT, 12'd0},
        // Clearing an owner that holds nothing still succeeds.
        '{FIRST, CLEAR, 16'hffff, 13'd0,    1'b1, DONE,  12'd0},
        // The whole store for one owner, then a full store, then freed again.
        '{FIRST, ALLOC, 16'hffff, 13'd4096, 1'b1, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0002, 13'd1,    1'b1, NOFIT, 12'd0},
        '{FIRST, CLEAR, 16'hffff, 13'd8191, 1'b1, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0001, 13'd10,   1'b1, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0002, 13'd20,   1'b0, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0003, 13'd5,    1'b0, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0004, 13'd40,   1'b0, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h0005, 13'd3,    1'b0, DONE,  12'd0},
        '{FIRST, CLEAR, 16'h0001, 13'd0,    1'b0, DONE,  12'd0},
        '{FIRST, CLEAR, 16'h0003, 13'd0,    1'b0, DONE,  12'd0},
        '{BEST,  ALLOC, 16'h0006, 13'd4,    1'b0, DONE,  12'd0},
        '{WORST, ALLOC, 16'h0007, 13'd2,    1'b0, DONE,  12'd0},
        '{POLICY_UNUSED, ALLOC, 16'h0008, 13'd1, 1'b0, DONE, 12'd0},
        // A one-cell hole left behind by best fit is the best fit now.
        '{BEST,  ALLOC, 16'h0009, 13'd1,    1'b0, DONE,  12'd0},
        '{WORST, ALLOC, 16'h000a, 13'd4016, 1'b0, DONE,  12'd0},
        // Only a nine-cell hole is left, so ten cells cannot fit.
        '{FIRST, ALLOC, 16'h000b, 13'd10,   1'b0, DONE,  12'd0},
        '{FIRST, ALLOC, 16'h8000, 13'd9,    1'b0, DONE,  12'd0},
        '{FIRST, CLEAR, 16'h000a, 13'd0,    1'b0, DONE,  12'd0}
    };

    // Random blocks walk through every policy, the unused encoding included.
    cfa_pkg::policy_t block_policy [6] = '{BEST, WORST, POLICY_UNUSED,
                                           FIRST, WORST, BEST};
    int      sender_idle_pct [3]   = '{17, 66, 0};
    int      receiver_idle_pct [3] = '{66, 17, 0};

    logic clk = 1'b0;
    logic rst_n;

    cfa_cfg_if cfg_ch ();
    cfa_req_if req_ch ();
    cfa_rsp_if rsp_ch ();

    contiguous_fit_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_ch),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow of the block: the owner store and the placement policy.
    cfa_pkg::owner_t  model_cells [CELLS];
    cfa_pkg::policy_t model_policy;

    // Results the block still owes, oldest first.
    alloc_result_t owed_results [$];

    int mismatch_count = 0;
    int tx_idle_pct    = 0;
    int rx_idle_pct    = 0;
    int quiet_cycles   = 0;
    int hold_left      = 0;
    bit hold_req       = 1'b0;
    bit hold_ack       = 1'b0;

    // Applies one request to the shadow store and returns the result the
    // block must give for it. A hole is a maximal run of free cells, and it
    // is only judged once it has ended, so best fit compares whole holes.
    function automatic alloc_result_t place_request(logic cmd, cfa_pkg::owner_t owner,
                                                    cfa_pkg::size_t size);
        alloc_result_t res;
        int  need;
        int  run_start;
        int  run_len;
        int  pick_start;
        int  pick_len;
        bit  found;
        bit  free_cell;

        res.status      = cfa_pkg::ST_DONE;
        res.start_index = '0;
        need            = int'(size);
        found           = 1'b0;
        pick_start      = 0;
        pick_len        = 0;
        run_start       = 0;
        run_len         = 0;

        if (owner == cfa_pkg::OWNER_FREE)
            res.status = cfa_pkg::ST_BAD;
        else if (cmd == cfa_pkg::CMD_CLEAR)
        begin
            foreach (model_cells[i])
                if (model_cells[i] == owner)
                    model_cells[i] = cfa_pkg::OWNER_FREE;
        end
        else if (need == 0)
            res.status = cfa_pkg::ST_BAD;
        else
        begin
            if (need <= CELLS)
            begin
                // One step past the last cell closes a hole that runs to the end.
                for (int i = 0; i <= CELLS; i++)
                begin
                    if (i < CELLS)
                        free_cell = (model_cells[i] == cfa_pkg::OWNER_FREE);
                    else
                        free_cell = 1'b0;
                    if (free_cell)
                    begin
                        if (run_len == 0)
                            run_start = i;
                        run_len++;
                    end
                    else
                    begin
                        if (run_len >= need)
                        begin
                            if (!found)
                            begin
                                found      = 1'b1;
                                pick_start = run_start;
                                pick_len   = run_len;
                            end
                            else if (model_policy == cfa_pkg::POLICY_BEST
                                     && run_len < pick_len)
                            begin
                                pick_start = run_start;
                                pick_len   = run_len;
                            end
                            else if (model_policy == cfa_pkg::POLICY_WORST
                                     && run_len > pick_len)
                            begin
                                pick_start = run_start;
                                pick_len   = run_len;
                            end
                            // First fit, and the unused encoding, stop at the
                            // first hole that is long enough.
                            if (model_policy != cfa_pkg::POLICY_BEST
                                && model_policy != cfa_pkg::POLICY_WORST)
                                break;
                        end
                        run_len = 0;
                    end
                end
            end
            if (!found)
                res.status = cfa_pkg::ST_NOFIT;
            else
            begin
                for (int k = 0; k < need; k++)
                    model_cells[pick_start + k] = owner;
                res.start_index = cfa_pkg::start_t'(pick_start);
            end
        end
        return res;
    endfunction

    // Offers one request beat and waits for it to be taken. Valid stays high
    // after the handshake, so that back-to-back requests need no gap; a gap,
    // when one is drawn, lowers it first.
    task automatic send_request(input logic cmd, input cfa_pkg::owner_t owner,
                                input cfa_pkg::size_t size, input bit known,
                                input alloc_result_t typed);
        int            gap;
        alloc_result_t predicted;

        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= cmd;
        req_ch.owner_id   <= owner;
        req_ch.alloc_size <= size;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        predicted = place_request(cmd, owner, size);
        owed_results.push_back(known ? typed : predicted);
    endtask

    // Stops offering requests and waits until the block owes nothing. Every
    // request gives exactly one result, so an empty queue means an idle block.
    task automatic wait_results_in();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (owed_results.size() != 0);
    endtask

    task automatic write_policy(input cfa_pkg::policy_t policy);
        wait_results_in();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= policy;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        model_policy = policy;
    endtask

    // Random request, weighted toward well-formed allocations and clears over
    // the owner pool, with a minority of bad, oversize and very large ones.
    task automatic send_random_request();
        int              pick;
        logic            cmd;
        cfa_pkg::owner_t owner;
        cfa_pkg::size_t  size;

        pick = $urandom_range(99);
        cmd  = cfa_pkg::CMD_ALLOC;
        if ($urandom_range(99) < 85)
            owner = cfa_pkg::owner_t'($urandom_range(1, OWNER_POOL));
        else
            owner = cfa_pkg::owner_t'($urandom_range(1, 65535));
        size = cfa_pkg::size_t'($urandom_range(1, 64));

        if (pick < 3)
        begin
            cmd   = ($urandom_range(1) == 0) ? cfa_pkg::CMD_ALLOC : cfa_pkg::CMD_CLEAR;
            owner = cfa_pkg::OWNER_FREE;
            size  = cfa_pkg::size_t'($urandom);
        end
        else if (pick < 6)
            size = '0;
        else if (pick < 9)
            size = cfa_pkg::size_t'($urandom_range(CELLS + 1, int'(SIZE_MAX)));
        else if (pick < 12)
            size = cfa_pkg::size_t'($urandom_range(1024, CELLS));
        else if (pick < 40)
        begin
            cmd  = cfa_pkg::CMD_CLEAR;
            size = cfa_pkg::size_t'($urandom);
        end
        else if (pick < 60)
            size = cfa_pkg::size_t'($urandom_range(65, 512));
        send_request(cmd, owner, size, 1'b0, '0);
    endtask

    // Response side. Ready is redrawn every cycle from the current idle rate;
    // a toggle of hold_req starts a long hold-off counted here, during which
    // the block keeps its result and therefore stops taking requests.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (hold_req != hold_ack)
        begin
            hold_ack     <= hold_req;
            hold_left    <= LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Each result beat is checked against the oldest owed result.
    always @(posedge clk)
    begin : result_check
        alloc_result_t want;

        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("result beat with none owed: status %0d start_index %0d",
                             rsp_ch.status, rsp_ch.start_index);
            end
            else
            begin
                want = owed_results.pop_front();
                if (rsp_ch.status !== want.status
                    || rsp_ch.start_index !== want.start_index)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"result mismatch: status %0d (expected %0d), ",
                                  "start_index %0d (expected %0d)"},
                                 rsp_ch.status, want.status,
                                 rsp_ch.start_index, want.start_index);
                end
            end
        end
    end

    // Watchdog: any beat on any channel counts as progress. The limit covers
    // the clearing pass after reset, a full scan and fill, and the long hold.
    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("** contiguous_fit_allocator: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid      <= 1'b0;
        req_ch.cmd        <= cfa_pkg::CMD_ALLOC;
        req_ch.owner_id   <= cfa_pkg::OWNER_FREE;
        req_ch.alloc_size <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= cfa_pkg::POLICY_FIRST;
        foreach (model_cells[i])
            model_cells[i] = cfa_pkg::OWNER_FREE;
        model_policy = cfa_pkg::POLICY_FIRST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, with the sender idling lightly and the receiver a lot.
        tx_idle_pct = sender_idle_pct[0];
        rx_idle_pct = receiver_idle_pct[0];
        write_policy(cfa_pkg::POLICY_FIRST);
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].policy != model_policy)
                write_policy(directed_rows[r].policy);
            send_request(directed_rows[r].cmd, directed_rows[r].owner, directed_rows[r].size,
                         directed_rows[r].known,
                         alloc_result_t'{directed_rows[r].status,
                                         directed_rows[r].start_index});
        end

        // Random part: three idling modes, two policy blocks in each.
        for (int mode = 0; mode < 3; mode++)
        begin
            tx_idle_pct = sender_idle_pct[mode];
            rx_idle_pct = receiver_idle_pct[mode];
            for (int blk = 0; blk < 2; blk++)
            begin
                write_policy(block_policy[2 * mode + blk]);
                if (mode == 2 && blk == 0)
                begin
                    // Hold the response side off while requests keep coming,
                    // so that the block sits on a result and stalls its input.
                    hold_req <= ~hold_req;
                    send_request(cfa_pkg::CMD_ALLOC,
                                 cfa_pkg::owner_t'($urandom_range(1, OWNER_POOL)),
                                 cfa_pkg::size_t'($urandom_range(1, 16)), 1'b0, '0);
                    repeat (4)
                        send_request(cfa_pkg::CMD_ALLOC, cfa_pkg::OWNER_FREE,
                                     cfa_pkg::size_t'($urandom), 1'b0, '0);
                    wait_results_in();
                end
                repeat (ITEMS_PER_BLOCK)
                    send_random_request();
            end
        end

        // Let everything owed come back, then watch for stray results for
        // about as long as the slowest request takes.
        wait_results_in();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && owed_results.size() == 0)
            $display("** contiguous_fit_allocator: PASSED **");
        else
            $display("** contiguous_fit_allocator: FAILED **");
        $finish;
    end

endmodule

@@ contiguous_fit_allocator.f @@
design/cfa_pkg.sv
design/cfa_if.sv
design/contiguous_fit_allocator.sv
bench/contiguous_fit_allocator_test.sv
